/* rtl/idd_pkg.sv */
// Shared types and constants for the incremental deadlock detector.
// No dependencies; every other file of the block imports this package.
package idd_pkg;

  localparam int unsigned PROCS_DEF  = 32;
  localparam int unsigned RES_DEF    = 32;

  localparam int unsigned PROC_W     = 5;
  localparam int unsigned RES_W      = 5;
  localparam int unsigned IDX_W      = 16;
  localparam logic [IDX_W-1:0] IDX_MAX = '1;

  localparam logic DIR_REQUEST = 1'b0;
  localparam logic DIR_ASSIGN  = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PEEL,
    S_SCAN,
    S_CLEAR
  } idd_state_e;

  // Controller to datapath
  typedef struct packed {
    logic store_arc;  // store the edge, count it, restart peeling
    logic peel;       // run one peeling round
    logic emit;       // load a deadlocked process into the output register
    logic emit_clear; // load the no-deadlock result
    logic advance;    // step the scan index
  } idd_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic changed;    // peeling round altered the live sets
    logic live_any;   // at least one live process
    logic cur_live;   // process under the scan index is live
    logic rest_empty; // no other live process besides the one under the index
    logic out_free;   // output register can take a result this cycle
  } idd_status_t;

endpackage

/* rtl/idd_edge_if.sv */
// Edge channel: one graph edge per request, valid/ready handshake.
// Depends on idd_pkg for the field widths.
interface idd_edge_if;
  import idd_pkg::*;

  logic              valid;
  logic              ready;
  logic [PROC_W-1:0] proc_num;
  logic [RES_W-1:0]  res_num;
  logic              direction;

  modport source (output valid, proc_num, res_num, direction, input ready);
  modport sink   (input valid, proc_num, res_num, direction, output ready);
endinterface

/* rtl/idd_result_if.sv */
// Result channel: one deadlocked process (or the all-clear) per request.
// Depends on idd_pkg for the field widths.
interface idd_result_if;
  import idd_pkg::*;

  logic              valid;
  logic              ready;
  logic              deadlock;
  logic [PROC_W-1:0] stuck_proc;
  logic [IDX_W-1:0]  edge_index;
  logic              last;

  modport source (output valid, deadlock, stuck_proc, edge_index, last, input ready);
  modport sink   (input valid, deadlock, stuck_proc, edge_index, last, output ready);
endinterface

/* rtl/incremental_deadlock_detector.sv */
// Incremental deadlock detector over a resource-allocation graph.
// An edge is accepted, then peeling rounds run one per cycle until a round changes nothing,
// then a scan reports each live process (or the all-clear); output stalls hold either.
// The next edge is taken only once the last result sits in the output register.
// Reset (asynchronous, active low) clears both matrices and the edge counter at once.
module incremental_deadlock_detector #(
  parameter int unsigned PROCS     = idd_pkg::PROCS_DEF,
  parameter int unsigned RESOURCES = idd_pkg::RES_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  idd_edge_if.sink      edge_i,
  idd_result_if.source  result_o
);
  import idd_pkg::*;

  idd_cmd_t    cmd;
  idd_status_t status;

  idd_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .edge_valid_i (edge_i.valid),
    .edge_ready_o (edge_i.ready),
    .status_i     (status),
    .cmd_o        (cmd)
  );

  idd_datapath #(
    .PROCS     (PROCS),
    .RESOURCES (RESOURCES)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .edge_proc_i    (edge_i.proc_num),
    .edge_res_i     (edge_i.res_num),
    .edge_dir_i     (edge_i.direction),
    .out_valid_o    (result_o.valid),
    .out_ready_i    (result_o.ready),
    .out_deadlock_o (result_o.deadlock),
    .out_stuck_o    (result_o.stuck_proc),
    .out_index_o    (result_o.edge_index),
    .out_last_o     (result_o.last)
  );

endmodule

/* rtl/idd_ctrl.sv */
// Controller of the deadlock detector: accept, peel to a fixed point, report.
// Depends on idd_pkg; drives the datapath through idd_cmd_t only.
module idd_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                edge_valid_i,
  output logic                edge_ready_o,
  input  idd_pkg::idd_status_t status_i,
  output idd_pkg::idd_cmd_t   cmd_o
);
  import idd_pkg::*;

  idd_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (edge_valid_i) begin
          state_d = S_PEEL;
        end
      end
      S_PEEL: begin
        if (!status_i.changed) begin
          state_d = status_i.live_any ? S_SCAN : S_CLEAR;
        end
      end
      S_SCAN: begin
        if (status_i.cur_live && status_i.out_free && status_i.rest_empty) begin
          state_d = S_IDLE;
        end
      end
      S_CLEAR: begin
        if (status_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o        = '0;
    edge_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        edge_ready_o    = 1'b1;
        cmd_o.store_arc = edge_valid_i;
      end
      S_PEEL: begin
        cmd_o.peel = 1'b1;
      end
      S_SCAN: begin
        // skip dead processes at once; a live one waits for the output slot
        if (!status_i.cur_live) begin
          cmd_o.advance = 1'b1;
        end else if (status_i.out_free) begin
          cmd_o.emit    = 1'b1;
          cmd_o.advance = !status_i.rest_empty;
        end
      end
      S_CLEAR: begin
        cmd_o.emit_clear = status_i.out_free;
      end
      default: ;
    endcase
  end

  a_scan_has_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> status_i.live_any)
    else $error("scan running with no live process");

  a_clear_no_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> !status_i.live_any)
    else $error("all-clear pending while a process is live");

  a_scan_ends_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN && state_d == S_IDLE) |-> (cmd_o.emit && status_i.rest_empty))
    else $error("scan left without emitting the final process");

endmodule

/* rtl/idd_datapath.sv */
// Datapath of the deadlock detector: adjacency matrices, live sets,
// peeling round, scan index, edge counter and the output register. Uses idd_pkg.
module idd_datapath #(
  parameter int unsigned PROCS     = idd_pkg::PROCS_DEF,
  parameter int unsigned RESOURCES = idd_pkg::RES_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  idd_pkg::idd_cmd_t                cmd_i,
  output idd_pkg::idd_status_t             status_o,
  input  logic [idd_pkg::PROC_W-1:0]       edge_proc_i,
  input  logic [idd_pkg::RES_W-1:0]        edge_res_i,
  input  logic                             edge_dir_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic                             out_deadlock_o,
  output logic [idd_pkg::PROC_W-1:0]       out_stuck_o,
  output logic [idd_pkg::IDX_W-1:0]        out_index_o,
  output logic                             out_last_o
);
  import idd_pkg::*;

  localparam int unsigned PW = $clog2(PROCS);
  localparam int unsigned RW = $clog2(RESOURCES);

  logic [RESOURCES-1:0] req_q [PROCS];      // row p: resources process p waits on
  logic [PROCS-1:0]     asg_q [RESOURCES];  // row r: processes holding resource r
  logic [PROCS-1:0]     live_p_q, np;
  logic [RESOURCES-1:0] live_r_q, nr;
  logic [PW-1:0]        scan_q;
  logic [IDX_W-1:0]     cnt_q, idx_q;
  logic                 out_valid_q, out_valid_d;
  logic                 out_dl_q, out_last_q;
  logic [PROC_W-1:0]    out_stuck_q;
  logic [IDX_W-1:0]     out_idx_q;
  logic                 in_range;
  logic [PW-1:0]        wr_p;
  logic [RW-1:0]        wr_r;
  logic [PROCS-1:0]     scan_sel;
  logic                 out_free;

  assign in_range = (32'(edge_proc_i) < 32'(PROCS)) && (32'(edge_res_i) < 32'(RESOURCES));
  assign wr_p     = PW'(edge_proc_i);
  assign wr_r     = RW'(edge_res_i);

  // One peeling round: processes first, then resources against the new process set
  always_comb begin
    for (int i = 0; i < PROCS; i++) begin
      np[i] = live_p_q[i] & (|(req_q[i] & live_r_q));
    end
    for (int j = 0; j < RESOURCES; j++) begin
      nr[j] = live_r_q[j] & (|(asg_q[j] & np));
    end
  end

  assign scan_sel = PROCS'(1) << scan_q;
  assign out_free = !out_valid_q || out_ready_i;

  assign status_o.changed    = (np != live_p_q) || (nr != live_r_q);
  assign status_o.live_any   = |live_p_q;
  assign status_o.cur_live   = live_p_q[scan_q];
  assign status_o.rest_empty = (live_p_q & ~scan_sel) == '0;
  assign status_o.out_free   = out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < PROCS; i++) begin
        req_q[i] <= '0;
      end
      for (int j = 0; j < RESOURCES; j++) begin
        asg_q[j] <= '0;
      end
      cnt_q <= '0;
    end else if (cmd_i.store_arc) begin
      if (in_range) begin
        if (edge_dir_i == DIR_REQUEST) begin
          req_q[wr_p][wr_r] <= 1'b1;
        end else begin
          asg_q[wr_r][wr_p] <= 1'b1;
        end
      end
      if (cnt_q != IDX_MAX) begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  // Live sets, scan index and captured edge index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_p_q <= '0;
      live_r_q <= '0;
      scan_q   <= '0;
      idx_q    <= '0;
    end else begin
      if (cmd_i.store_arc) begin
        live_p_q <= '1;
        live_r_q <= '1;
        scan_q   <= '0;
        idx_q    <= cnt_q;
      end else if (cmd_i.peel) begin
        live_p_q <= np;
        live_r_q <= nr;
      end else begin
        if (cmd_i.emit) begin
          live_p_q <= live_p_q & ~scan_sel;
        end
        if (cmd_i.advance) begin
          scan_q <= scan_q + 1'b1;
        end
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.emit || cmd_i.emit_clear) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_dl_q    <= 1'b1;
      out_stuck_q <= PROC_W'(scan_q);
      out_idx_q   <= idx_q;
      out_last_q  <= (live_p_q & ~scan_sel) == '0;
    end else if (cmd_i.emit_clear) begin
      out_dl_q    <= 1'b0;
      out_stuck_q <= '0;
      out_idx_q   <= idx_q;
      out_last_q  <= 1'b1;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_deadlock_o = out_dl_q;
  assign out_stuck_o    = out_stuck_q;
  assign out_index_o    = out_idx_q;
  assign out_last_o     = out_last_q;

  a_emit_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> live_p_q[scan_q])
    else $error("emitting a process that is not live");

  a_peel_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.peel |=> ((live_p_q & ~$past(live_p_q)) == '0))
    else $error("peeling revived a process");

  a_emit_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit || cmd_i.emit_clear) |-> out_free)
    else $error("result loaded over one not yet taken");

endmodule
